@@ hw/rtl/lfrg_pkg.sv @@
// Shared constants, types and helpers of the linear frequency ramp generator.
// No dependencies; imported by the ramp generator and its checker.
`default_nettype none

package lfrg_pkg;

    // Fixed-point and timing constants
    localparam int FRAC_BITS      = 16;
    localparam int TICKS_PER_UNIT = 100;

    // Field widths
    localparam int TIME_W    = 16;
    localparam int FREQ_W    = 20;
    localparam int SFREQ_W   = 21;
    localparam int SCALED_W  = 16;
    localparam int ACC_W     = 32;
    localparam int SHIFT_W   = 4;
    localparam int SHIFT_POS = 16;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Serial arithmetic widths
    localparam int TICK_W  = TIME_W + $clog2(TICKS_PER_UNIT + 1);
    localparam int PROD_W  = TICK_W + SCALED_W;
    localparam int QUO_W   = SCALED_W + FRAC_BITS;
    localparam int MAX_STEPS = (PROD_W > QUO_W) ? PROD_W : QUO_W;
    localparam int CNT_W   = $clog2(MAX_STEPS + 1);

    typedef logic [PHASE_W-1:0]  phase_t;
    typedef logic [SCALED_W-1:0] scaled_t;

    // Ramp phase codes
    localparam phase_t PH_ACC   = 2'd0;
    localparam phase_t PH_DEC   = 2'd1;
    localparam phase_t PH_CONST = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAXF  = 2'd2;

    // Configuration reset values
    localparam logic [TIME_W-1:0] ACCEL_RST = 16'd100;
    localparam logic [TIME_W-1:0] DECEL_RST = 16'd100;
    localparam logic [FREQ_W-1:0] MAXF_RST  = 20'd5000;

    localparam logic [ACC_W:0] ROUND_HALF = (ACC_W+1)'(1) << (FRAC_BITS - 1);

    // Saturate to the scaled width
    function automatic scaled_t sat16(input logic [31:0] v);
        scaled_t r;
        if (v > 32'h0000_FFFF) r = '1;
        else                   r = v[SCALED_W-1:0];
        return r;
    endfunction

    // Saturate to 32 bits, with a floor of one
    function automatic logic [31:0] sat32_floor1(input logic [63:0] v);
        logic [31:0] r;
        if (v > 64'h0000_0000_FFFF_FFFF) r = '1;
        else if (v == 64'd0)            r = 32'd1;
        else                            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/linear_frequency_ramp_generator.sv @@
// Linear frequency ramp generator: tick-driven acceleration/deceleration ramp with
// bit-serial slope computation. Depends on lfrg_pkg.
`default_nettype none

// One request per tick (op 0) or start-from-speed (op 1) gives exactly one result.
// A request that needs no new slope runs through S_LOAD, S_TGT and S_DECIDE into
// S_OUT: directly at constant speed, via S_STEP for a phase entry with a zero ramp
// time (jump to the target) and via S_STEP, which adds the slope, and S_ROUND,
// which rounds, for a ramp step. A phase entry with a nonzero ramp time recomputes
// the slope through one shared shift register datapath: a 16-step shift-add
// multiply of ramp ticks by distance, a PROD_W-step (39) restoring division by the
// scaled full scale and a QUO_W-step (32) restoring division of the distance by
// the scaled time, one bit per cycle. Requests are taken one at a time: in_stall
// stays high from accept until the result sits in the output register, which then
// holds it under out_stall while the next request is already accepted. Write the
// configuration only while the block is idle; cfg_ready is always high.
module linear_frequency_ramp_generator
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lfrg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lfrg_pkg::FREQ_W-1:0]        cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               op,
    input  wire logic                               run_cmd,
    input  wire logic                               run_dir,
    input  wire logic [lfrg_pkg::FREQ_W-1:0]        target_freq,
    input  wire logic signed [lfrg_pkg::SFREQ_W-1:0] start_speed,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [lfrg_pkg::FREQ_W-1:0]             ref_freq,
    output logic signed [lfrg_pkg::SFREQ_W-1:0]     signed_freq,
    output logic [lfrg_pkg::PHASE_W-1:0]            ramp_phase,
    output logic                                    cur_dir,
    output logic                                    target_changed
);
    import lfrg_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_TGT    = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_DIV1   = 4'd5;
    localparam logic [3:0] S_TIME   = 4'd6;
    localparam logic [3:0] S_DIV2   = 4'd7;
    localparam logic [3:0] S_SLOPE  = 4'd8;
    localparam logic [3:0] S_STEP   = 4'd9;
    localparam logic [3:0] S_ROUND  = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    // Configuration
    logic [TIME_W-1:0]   accel_time_reg, accel_time_next;
    logic [TIME_W-1:0]   decel_time_reg, decel_time_next;
    logic [FREQ_W-1:0]   max_freq_reg,   max_freq_next;

    logic [3:0]          state_reg, state_next;

    // Captured request
    logic                op_reg,      op_next;
    logic                run_cmd_reg, run_cmd_next;
    logic                run_dir_reg, run_dir_next;
    logic [FREQ_W-1:0]   target_reg,  target_next;
    logic [SFREQ_W-1:0]  start_reg,   start_next;

    // Ramp state
    phase_t              phase_reg,       phase_next;
    logic                dir_reg,         dir_next;
    scaled_t             outf_reg,        outf_next;
    logic [ACC_W-1:0]    acc_reg,         acc_next;
    logic [31:0]         slope_reg,       slope_next;
    logic [FREQ_W-1:0]   prev_target_reg, prev_target_next;
    logic [TIME_W-1:0]   prev_accel_reg,  prev_accel_next;
    logic [TIME_W-1:0]   prev_decel_reg,  prev_decel_next;

    // Per-request working values
    scaled_t             set_reg,     set_next;
    logic                tgt_chg_reg, tgt_chg_next;
    logic                acc_chg_reg, acc_chg_next;
    logic                dec_chg_reg, dec_chg_next;
    logic                reload_reg,  reload_next;
    scaled_t             dist_reg,    dist_next;

    // Serial slope datapath
    logic [TICK_W-1:0]   mcand_reg, mcand_next;
    logic [PROD_W-1:0]   work_reg,  work_next;
    logic [FREQ_W-1:0]   rem1_reg,  rem1_next;
    logic [31:0]         time_reg,  time_next;
    logic [31:0]         rem2_reg,  rem2_next;
    logic [QUO_W-1:0]    quo_reg,   quo_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;

    // Output register
    logic                out_valid_reg,  out_valid_next;
    logic [FREQ_W-1:0]   ref_freq_reg,   ref_freq_next;
    logic [SFREQ_W-1:0]  sfreq_reg,      sfreq_next;
    phase_t              ophase_reg,     ophase_next;
    logic                odir_reg,       odir_next;
    logic                otchg_reg,      otchg_next;

    // Derived from configuration
    logic [SHIFT_W-1:0]  shift_amt;
    logic [FREQ_W-1:0]   max_scaled;
    logic [FREQ_W-1:0]   divisor;

    // Datapath helpers
    logic [SFREQ_W-1:0]  start_mag;
    logic [FREQ_W-1:0]   tgt_raw;
    logic [FREQ_W-1:0]   tgt_eff;
    logic                dir_mismatch;
    logic                enter;
    logic [TICK_W:0]     mul_sum;
    logic [FREQ_W+1:0]   div1_diff;
    logic [33:0]         div2_diff;
    logic [31:0]         slope_sat;
    logic [31:0]         slope_shr;
    logic [ACC_W-1:0]    acc_src;
    logic                ticks_nz;
    logic [30:0]         ref_wide;
    logic [FREQ_W-1:0]   ref_sat;
    logic                out_load;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);

    assign out_valid      = out_valid_reg;
    assign ref_freq       = ref_freq_reg;
    assign signed_freq    = $signed(sfreq_reg);
    assign ramp_phase     = ophase_reg;
    assign cur_dir        = odir_reg;
    assign target_changed = otchg_reg;

    assign shift_amt  = max_freq_reg[SHIFT_POS +: SHIFT_W];
    assign max_scaled = max_freq_reg >> shift_amt;
    assign divisor    = (max_scaled == '0) ? FREQ_W'(1) : max_scaled;

    // Magnitude of the measured speed; the most negative value maps to 2^20
    assign start_mag = start_reg[SFREQ_W-1] ? (SFREQ_W'(0) - start_reg) : start_reg;

    // Drop the target while a reversal waits for zero output
    assign tgt_raw      = run_cmd_reg ? target_reg : '0;
    assign dir_mismatch = (dir_reg != run_dir_reg);
    assign tgt_eff      = (dir_mismatch && (outf_reg != '0)) ? '0 : tgt_raw;

    // Re-enter the phase on a start request, on reaching the target, or on a
    // change of target or ramp time
    always_comb
    begin
        unique case (phase_reg)
            PH_ACC:   enter = (outf_reg >= set_reg) || tgt_chg_reg || acc_chg_reg;
            PH_DEC:   enter = (outf_reg <= set_reg) || tgt_chg_reg || dec_chg_reg;
            default:  enter = (outf_reg != set_reg);
        endcase
        enter = enter || op_reg;
    end

    // One bit of each serial unit per cycle
    assign mul_sum   = {1'b0, work_reg[PROD_W-1:SCALED_W]}
                     + (work_reg[0] ? {1'b0, mcand_reg} : '0);
    assign div1_diff = {1'b0, rem1_reg, work_reg[PROD_W-1]} - {2'b00, divisor};
    assign div2_diff = {1'b0, rem2_reg, quo_reg[QUO_W-1]} - {2'b00, time_reg};

    assign slope_sat = sat32_floor1(64'(quo_reg));
    assign slope_shr = slope_sat >> shift_amt;

    assign acc_src  = reload_reg ? 32'(64'(outf_reg) << FRAC_BITS) : acc_reg;
    assign ticks_nz = (phase_reg == PH_ACC) ? (accel_time_reg != '0)
                                            : (decel_time_reg != '0);

    assign ref_wide = 31'(outf_reg) << shift_amt;
    assign ref_sat  = (ref_wide > 31'(20'hF_FFFF)) ? '1 : ref_wide[FREQ_W-1:0];

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        accel_time_next  = accel_time_reg;
        decel_time_next  = decel_time_reg;
        max_freq_next    = max_freq_reg;
        state_next       = state_reg;
        op_next          = op_reg;
        run_cmd_next     = run_cmd_reg;
        run_dir_next     = run_dir_reg;
        target_next      = target_reg;
        start_next       = start_reg;
        phase_next       = phase_reg;
        dir_next         = dir_reg;
        outf_next        = outf_reg;
        acc_next         = acc_reg;
        slope_next       = slope_reg;
        prev_target_next = prev_target_reg;
        prev_accel_next  = prev_accel_reg;
        prev_decel_next  = prev_decel_reg;
        set_next         = set_reg;
        tgt_chg_next     = tgt_chg_reg;
        acc_chg_next     = acc_chg_reg;
        dec_chg_next     = dec_chg_reg;
        reload_next      = reload_reg;
        dist_next        = dist_reg;
        mcand_next       = mcand_reg;
        work_next        = work_reg;
        rem1_next        = rem1_reg;
        time_next        = time_reg;
        rem2_next        = rem2_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && out_stall;
        ref_freq_next    = ref_freq_reg;
        sfreq_next       = sfreq_reg;
        ophase_next      = ophase_reg;
        odir_next        = odir_reg;
        otchg_next       = otchg_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ACCEL: accel_time_next = cfg_data[TIME_W-1:0];
                REG_DECEL: decel_time_next = cfg_data[TIME_W-1:0];
                REG_MAXF:  max_freq_next   = cfg_data;
                default:   ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = op;
                    run_cmd_next = run_cmd;
                    run_dir_next = run_dir;
                    target_next  = target_freq;
                    start_next   = start_speed;
                    state_next   = S_LOAD;
                end
            end

            S_LOAD:
            begin
                // Start request: load the ramp from the measured speed
                if (op_reg)
                begin
                    slope_next = '0;
                    acc_next   = '0;
                    dir_next   = start_reg[SFREQ_W-1];
                    outf_next  = sat16(32'(start_mag >> shift_amt));
                end
                state_next = S_TGT;
            end

            S_TGT:
            begin
                if (dir_mismatch && (outf_reg == '0))
                    dir_next = run_dir_reg;
                tgt_chg_next     = (prev_target_reg != tgt_eff);
                prev_target_next = tgt_eff;
                set_next         = sat16(32'(tgt_eff >> shift_amt));
                acc_chg_next     = (prev_accel_reg != accel_time_reg);
                dec_chg_next     = (prev_decel_reg != decel_time_reg);
                prev_accel_next  = accel_time_reg;
                prev_decel_next  = decel_time_reg;
                state_next       = S_DECIDE;
            end

            S_DECIDE:
            begin
                reload_next = enter;
                if (!enter)
                begin
                    state_next = (phase_reg == PH_CONST) ? S_OUT : S_STEP;
                end
                else if (outf_reg == set_reg)
                begin
                    phase_next = PH_CONST;
                    slope_next = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    if (outf_reg > set_reg)
                    begin
                        phase_next = PH_DEC;
                        dist_next  = outf_reg - set_reg;
                        mcand_next = TICK_W'(decel_time_reg) * TICK_W'(TICKS_PER_UNIT);
                        work_next  = PROD_W'(outf_reg - set_reg);
                        state_next = (decel_time_reg != '0) ? S_MUL : S_STEP;
                    end
                    else
                    begin
                        phase_next = PH_ACC;
                        dist_next  = set_reg - outf_reg;
                        mcand_next = TICK_W'(accel_time_reg) * TICK_W'(TICKS_PER_UNIT);
                        work_next  = PROD_W'(set_reg - outf_reg);
                        state_next = (accel_time_reg != '0) ? S_MUL : S_STEP;
                    end
                    cnt_next = CNT_W'(SCALED_W);
                end
            end

            S_MUL:
            begin
                // Shift-add: ticks times distance, one distance bit per cycle
                work_next = {mul_sum, work_reg[SCALED_W-1:1]};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    rem1_next  = '0;
                    cnt_next   = CNT_W'(PROD_W);
                    state_next = S_DIV1;
                end
            end

            S_DIV1:
            begin
                // Restoring division of the product by the scaled full scale
                if (div1_diff[FREQ_W+1])
                    rem1_next = {rem1_reg[FREQ_W-2:0], work_reg[PROD_W-1]};
                else
                    rem1_next = div1_diff[FREQ_W-1:0];
                work_next = {work_reg[PROD_W-2:0], ~div1_diff[FREQ_W+1]};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    state_next = S_TIME;
            end

            S_TIME:
            begin
                time_next  = sat32_floor1(64'(work_reg));
                rem2_next  = '0;
                quo_next   = QUO_W'(dist_reg) << FRAC_BITS;
                cnt_next   = CNT_W'(QUO_W);
                state_next = S_DIV2;
            end

            S_DIV2:
            begin
                // Restoring division of distance (fixed point) by the scaled time
                if (div2_diff[33])
                    rem2_next = {rem2_reg[30:0], quo_reg[QUO_W-1]};
                else
                    rem2_next = div2_diff[31:0];
                quo_next = {quo_reg[QUO_W-2:0], ~div2_diff[33]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    state_next = S_SLOPE;
            end

            S_SLOPE:
            begin
                slope_next = (slope_shr == '0) ? 32'd1 : slope_shr;
                state_next = S_STEP;
            end

            S_STEP:
            begin
                if (ticks_nz)
                begin
                    if (phase_reg == PH_ACC)
                        acc_next = acc_src + slope_reg;
                    else if (acc_src <= slope_reg)
                        acc_next = '0;
                    else
                        acc_next = acc_src - slope_reg;
                    state_next = S_ROUND;
                end
                else
                begin
                    // Zero ramp time: jump to the target
                    acc_next   = acc_src;
                    outf_next  = set_reg;
                    state_next = S_OUT;
                end
            end

            S_ROUND:
            begin
                outf_next  = sat16(32'(((ACC_W+1)'(acc_reg) + ROUND_HALF) >> FRAC_BITS));
                state_next = S_OUT;
            end

            S_OUT:
            begin
                // Hold here until the output register is free
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    ref_freq_next  = ref_sat;
                    sfreq_next     = dir_reg ? (SFREQ_W'(0) - {1'b0, ref_sat})
                                             : {1'b0, ref_sat};
                    ophase_next    = phase_reg;
                    odir_next      = dir_reg;
                    otchg_next     = tgt_chg_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_time_reg  <= ACCEL_RST;
            decel_time_reg  <= DECEL_RST;
            max_freq_reg    <= MAXF_RST;
            state_reg       <= S_IDLE;
            op_reg          <= 1'b0;
            run_cmd_reg     <= 1'b0;
            run_dir_reg     <= 1'b0;
            target_reg      <= '0;
            start_reg       <= '0;
            phase_reg       <= PH_CONST;
            dir_reg         <= 1'b0;
            outf_reg        <= '0;
            acc_reg         <= '0;
            slope_reg       <= '0;
            prev_target_reg <= '0;
            prev_accel_reg  <= '0;
            prev_decel_reg  <= '0;
            set_reg         <= '0;
            tgt_chg_reg     <= 1'b0;
            acc_chg_reg     <= 1'b0;
            dec_chg_reg     <= 1'b0;
            reload_reg      <= 1'b0;
            dist_reg        <= '0;
            mcand_reg       <= '0;
            work_reg        <= '0;
            rem1_reg        <= '0;
            time_reg        <= '0;
            rem2_reg        <= '0;
            quo_reg         <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            ref_freq_reg    <= '0;
            sfreq_reg       <= '0;
            ophase_reg      <= PH_CONST;
            odir_reg        <= 1'b0;
            otchg_reg       <= 1'b0;
        end
        else
        begin
            accel_time_reg  <= accel_time_next;
            decel_time_reg  <= decel_time_next;
            max_freq_reg    <= max_freq_next;
            state_reg       <= state_next;
            op_reg          <= op_next;
            run_cmd_reg     <= run_cmd_next;
            run_dir_reg     <= run_dir_next;
            target_reg      <= target_next;
            start_reg       <= start_next;
            phase_reg       <= phase_next;
            dir_reg         <= dir_next;
            outf_reg        <= outf_next;
            acc_reg         <= acc_next;
            slope_reg       <= slope_next;
            prev_target_reg <= prev_target_next;
            prev_accel_reg  <= prev_accel_next;
            prev_decel_reg  <= prev_decel_next;
            set_reg         <= set_next;
            tgt_chg_reg     <= tgt_chg_next;
            acc_chg_reg     <= acc_chg_next;
            dec_chg_reg     <= dec_chg_next;
            reload_reg      <= reload_next;
            dist_reg        <= dist_next;
            mcand_reg       <= mcand_next;
            work_reg        <= work_next;
            rem1_reg        <= rem1_next;
            time_reg        <= time_next;
            rem2_reg        <= rem2_next;
            quo_reg         <= quo_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            ref_freq_reg    <= ref_freq_next;
            sfreq_reg       <= sfreq_next;
            ophase_reg      <= ophase_next;
            odir_reg        <= odir_next;
            otchg_reg       <= otchg_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lfrg_checker.sv @@
// Port-level checks of the linear frequency ramp generator, bound to its top level.
// Depends on lfrg_pkg and linear_frequency_ramp_generator.
`default_nettype none

module lfrg_checker
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic [lfrg_pkg::FREQ_W-1:0]        ref_freq,
    input wire logic signed [lfrg_pkg::SFREQ_W-1:0] signed_freq,
    input wire logic                               cur_dir
);
    import lfrg_pkg::*;

    // A request occupies the block: no back-to-back accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while the previous one is in flight");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ref_freq) && $stable(signed_freq))
        else $error("stalled result changed or dropped");

    // Signed frequency follows magnitude and direction
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cur_dir ? (signed_freq == $signed(SFREQ_W'(0) - SFREQ_W'(ref_freq)))
                               : (signed_freq == $signed(SFREQ_W'(ref_freq)))))
        else $error("signed_freq does not match ref_freq and cur_dir");

    // A result only appears at the end of a request's work
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced while idle");

endmodule

bind linear_frequency_ramp_generator lfrg_checker u_lfrg_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ref_freq    (ref_freq),
    .signed_freq (signed_freq),
    .cur_dir     (cur_dir)
);

`default_nettype wire
